>>> design/gbg_pkg.sv
`timescale 1ns / 1ps
package gbg_pkg;

  localparam int unsigned AtanN = 24;
  localparam int unsigned CordW = 40;
  localparam logic signed [CordW-1:0] PiQ20 = 40'sd3294199;
  localparam logic signed [31:0] KinvQ30 = 32'sd652032874;
  localparam int HeadMax = 12868;
  localparam int OneQ14 = 16384;

  localparam logic [1:0] CfgGoalLineX = 2'd0;
  localparam logic [1:0] CfgGoalWidth = 2'd1;
  localparam logic [1:0] CfgRobotNumber = 2'd2;

  typedef enum logic [1:0] {
    CordVec,
    CordRot
  } cord_mode_e;

  function automatic logic signed [CordW-1:0] atan_q20(input logic [4:0] i);
    logic signed [CordW-1:0] r;
    unique case (i)
      5'd0: r = 40'sd823550;
      5'd1: r = 40'sd486170;
      5'd2: r = 40'sd256879;
      5'd3: r = 40'sd130396;
      5'd4: r = 40'sd65451;
      5'd5: r = 40'sd32757;
      5'd6: r = 40'sd16383;
      5'd7: r = 40'sd8192;
      5'd8: r = 40'sd4096;
      5'd9: r = 40'sd2048;
      5'd10: r = 40'sd1024;
      5'd11: r = 40'sd512;
      5'd12: r = 40'sd256;
      5'd13: r = 40'sd128;
      5'd14: r = 40'sd64;
      5'd15: r = 40'sd32;
      5'd16: r = 40'sd16;
      5'd17: r = 40'sd8;
      5'd18: r = 40'sd4;
      5'd19: r = 40'sd2;
      5'd20: r = 40'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/gbg_cordic.sv
`timescale 1ns / 1ps
module gbg_cordic #(
  parameter int unsigned Steps = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  gbg_pkg::cord_mode_e           mode_i,
  input  logic signed [gbg_pkg::CordW-1:0] x_i,
  input  logic signed [gbg_pkg::CordW-1:0] y_i,
  input  logic signed [gbg_pkg::CordW-1:0] z_i,
  output logic                          done_o,
  output logic signed [gbg_pkg::CordW-1:0] x_o,
  output logic signed [gbg_pkg::CordW-1:0] y_o,
  output logic signed [gbg_pkg::CordW-1:0] z_o
);
  localparam int unsigned N = (Steps < gbg_pkg::AtanN) ? Steps : gbg_pkg::AtanN;

  logic signed [gbg_pkg::CordW-1:0] x_q, y_q, z_q, xs, ys, at;
  logic [4:0] i_q;
  logic busy_q, done_q, dir;
  gbg_pkg::cord_mode_e mode_q;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = gbg_pkg::atan_q20(i_q);
  assign dir = (mode_q == gbg_pkg::CordVec) ? (y_q > 0) : (z_q >= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
      mode_q <= gbg_pkg::CordVec;
    end else begin
      done_q <= !start_i && busy_q && (i_q == 5'(N - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        i_q <= '0;
        mode_q <= mode_i;
        x_q <= x_i;
        y_q <= y_i;
        z_q <= z_i;
      end else if (busy_q) begin
        if ((mode_q == gbg_pkg::CordVec) == dir) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end
        i_q <= i_q + 5'd1;
        if (i_q == 5'(N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

>>> design/gbg_divider.sv
`timescale 1ns / 1ps
module gbg_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [47:0] quo_o
);
  logic [47:0] n_q, q_q;
  logic [79:0] r_q;
  logic [31:0] d_q;
  logic neg_q, busy_q, done_q;
  logic [5:0] c_q;
  logic [79:0] rs;
  logic [80:0] diff;

  assign rs = {r_q[78:0], n_q[47]};
  assign diff = {1'b0, rs} - {49'd0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      c_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (c_q == 6'd47);
      if (start_i) begin
        busy_q <= 1'b1;
        c_q <= '0;
        neg_q <= num_i[47];
        n_q <= (num_i[47] ? -num_i : num_i) + 48'({16'd0, den_i} >> 1);
        d_q <= den_i;
        r_q <= '0;
        q_q <= '0;
      end else if (busy_q) begin
        n_q <= {n_q[46:0], 1'b0};
        if (!diff[80]) begin
          r_q <= diff[79:0];
          q_q <= {q_q[46:0], 1'b1};
        end else begin
          r_q <= rs;
          q_q <= {q_q[46:0], 1'b0};
        end
        c_q <= c_q + 6'd1;
        if (c_q == 6'd47) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o = (d_q == '0) ? '0 : (neg_q ? -$signed(q_q) : $signed(q_q));
endmodule

>>> design/goal_bisector_guard_position.sv
`timescale 1ns / 1ps
// A ball position that moves the target is turned into its beat through four CORDIC passes
// and five divider passes. A new position is taken only in Idle, once the last one has gone
// into the output register, or was dropped with no beat because the target moved too little;
// a result waits in an output register, and the next item stalls before its own result only
// while that register is still full.
// Reset restores the configuration defaults and forces a result for the first item.
module goal_bisector_guard_position #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // ball_pos_x, ball_pos_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // robot_tag, guard_x, guard_y, heading, quat_z, quat_w
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  localparam int W = gbg_pkg::CordW;

  typedef enum logic [4:0] {
    Idle, VecL, WaitL, VecR, WaitR, UnitA, UnitAW, UnitB, UnitBW, UnitC, UnitCW,
    UnitD, UnitDW, Blend, BlendW, Clamp, VecH, WaitH, Decide, Rot, WaitRot, Emit
  } state_e;

  state_e state_q;
  logic signed [13:0] glx_q, bx_q, by_q, tx_q, ty_q, px_q, py_q;
  logic [11:0] gw_q;
  logic [3:0] rn_q;
  logic signed [14:0] head_q, ph_q;
  logic have_q;
  logic signed [31:0] ml_q, mr_q;
  logic signed [16:0] ux_l_q, uy_l_q, ux_r_q, uy_r_q;
  logic signed [15:0] qz_q, qw_q;
  logic ovalid_q;
  logic [79:0] odata_q;
  logic emit_go;

  logic cs;
  gbg_pkg::cord_mode_e cm;
  logic signed [W-1:0] cx, cy, cz, cxo, cyo, czo;
  logic cdone;
  logic ds;
  logic signed [47:0] dn, dq;
  logic [31:0] dd;
  logic ddone;

  gbg_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs), .mode_i(cm), .x_i(cx), .y_i(cy), .z_i(cz),
    .done_o(cdone), .x_o(cxo), .y_o(cyo), .z_o(czo)
  );
  gbg_divider u_div (
    .clk_i, .rst_ni, .start_i(ds), .num_i(dn), .den_i(dd), .done_o(ddone), .quo_o(dq)
  );

  logic signed [15:0] vx2, vly2, vry2, hx, hy;
  logic signed [14:0] gap_s;
  logic [14:0] ball_gap;
  logic signed [16:0] sx, sy;
  logic [16:0] sxa;
  logic [16:0] den;
  logic signed [17:0] bd4;
  logic signed [34:0] bprod;
  logic signed [13:0] lim;
  logic signed [12:0] lim2;
  logic signed [W-1:0] vin_x, vin_y;
  logic signed [31:0] cxn;
  logic signed [63:0] magm;
  logic signed [63:0] magp;
  logic signed [31:0] mag;
  logic signed [W-1:0] hr;
  logic signed [16:0] hcl;
  logic signed [W-1:0] sr, cr;
  logic signed [16:0] qzc, qwc;
  logic signed [15:0] ddx, ddy, ddh;

  assign vx2 = 16'(2 * (32'(glx_q) - 32'(bx_q)));
  assign vly2 = 16'(32'(gw_q) - 2 * 32'(by_q));
  assign vry2 = 16'(-32'(gw_q) - 2 * 32'(by_q));
  assign hx = 16'(bx_q) - 16'(tx_q);
  assign hy = 16'(by_q) - 16'(ty_q);
  assign sx = ux_l_q + ux_r_q;
  assign sy = uy_l_q + uy_r_q;
  assign sxa = sx[16] ? 17'(-sx) : 17'(sx);
  assign den = (sxa < 17'd16) ? 17'd16 : sxa;
  assign bd4 = (18'(tx_q) - 18'(bx_q)) <<< 2;
  assign bprod = bd4 * sy;
  assign lim2 = (13'(gw_q) < 13'sd180) ? 13'sd0 : 13'($signed({1'b0, gw_q}) - 13'sd180);
  assign lim = 14'(lim2 >>> 1);
  assign gap_s = 15'(bx_q) - 15'(glx_q);
  assign ball_gap = gap_s[14] ? 15'(-gap_s) : 15'(gap_s);

  assign cxn = 32'(cxo);
  assign magm = cxn * gbg_pkg::KinvQ30;
  assign magp = (cxo < 0) ? 64'sd0 : magm + 64'sd536870912;
  assign mag = 32'(magp >>> 30);
  assign hr = (czo + 40'sd128) >>> 8;
  assign hcl = (hr > 40'sd12868) ? 17'sd12868 : (hr < -40'sd12868) ? -17'sd12868 : 17'(hr);
  assign sr = (cyo + 40'sd32768) >>> 16;
  assign cr = (cxo + 40'sd32768) >>> 16;
  assign qzc = (sr > 40'sd16384) ? 17'sd16384 : (sr < -40'sd16384) ? -17'sd16384 : 17'(sr);
  assign qwc = (cr > 40'sd16384) ? 17'sd16384 : (cr < -40'sd16384) ? -17'sd16384 : 17'(cr);
  assign ddx = 16'(tx_q) - 16'(px_q);
  assign ddy = 16'(ty_q) - 16'(py_q);
  assign ddh = 16'(head_q) - 16'(ph_q);
  assign emit_go = (state_q == Emit) && (!ovalid_q || m_axis_tready);

  function automatic logic signed [16:0] clamp14(input logic signed [47:0] v);
    return (v > 48'sd16384) ? 17'sd16384 : (v < -48'sd16384) ? -17'sd16384 : 17'(v);
  endfunction

  logic signed [15:0] vsx, vsy;
  always_comb begin
    vsx = vx2;
    vsy = vly2;
    if (state_q == VecR) vsy = vry2;
    if (state_q == VecH) begin
      vsx = hx;
      vsy = hy;
    end
    vin_x = W'(vsx) <<< 8;
    vin_y = W'(vsy) <<< 8;
    cs = 1'b0;
    cm = gbg_pkg::CordVec;
    cx = vin_x;
    cy = vin_y;
    cz = '0;
    if (state_q == VecL || state_q == VecR || state_q == VecH) begin
      cs = 1'b1;
      if (vin_x < 0) begin
        cx = -vin_x;
        cy = -vin_y;
        cz = (vin_y >= 0) ? gbg_pkg::PiQ20 : -gbg_pkg::PiQ20;
      end
    end
    if (state_q == Rot) begin
      cs = 1'b1;
      cm = gbg_pkg::CordRot;
      cx = W'(gbg_pkg::KinvQ30);
      cy = '0;
      cz = W'(head_q) <<< 7;
    end
    ds = 1'b0;
    dn = '0;
    dd = '0;
    unique case (state_q)
      UnitA: begin ds = 1'b1; dn = 48'(vx2) <<< 22; dd = 32'(ml_q); end
      UnitB: begin ds = 1'b1; dn = 48'(vly2) <<< 22; dd = 32'(ml_q); end
      UnitC: begin ds = 1'b1; dn = 48'(vx2) <<< 22; dd = 32'(mr_q); end
      UnitD: begin ds = 1'b1; dn = 48'(vry2) <<< 22; dd = 32'(mr_q); end
      Blend: begin
        ds = 1'b1;
        dn = 48'(bprod);
        dd = 32'(5 * 32'(den));
      end
      default: ;
    endcase
  end

  logic signed [47:0] tyw;
  assign tyw = 48'(by_q) + dq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      glx_q <= -14'sd4500;
      gw_q <= 12'd1000;
      rn_q <= '0;
      px_q <= '0;
      py_q <= '0;
      ph_q <= '0;
      have_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gbg_pkg::CfgGoalLineX: glx_q <= cfg_data_i;
          gbg_pkg::CfgGoalWidth: gw_q <= cfg_data_i[11:0];
          gbg_pkg::CfgRobotNumber: rn_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (emit_go) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        Idle: if (s_axis_tvalid) begin
          bx_q <= s_axis_tdata[13:0];
          by_q <= s_axis_tdata[27:14];
          state_q <= VecL;
        end
        VecL: begin
          if (ball_gap > 15'd3000) tx_q <= glx_q + (glx_q > 0 ? -14'sd400 : 14'sd400);
          else if (ball_gap > 15'd1500) tx_q <= glx_q + (glx_q > 0 ? -14'sd150 : 14'sd150);
          else tx_q <= glx_q;
          state_q <= WaitL;
        end
        WaitL: if (cdone) begin ml_q <= mag; state_q <= VecR; end
        VecR: state_q <= WaitR;
        WaitR: if (cdone) begin mr_q <= mag; state_q <= UnitA; end
        UnitA: state_q <= UnitAW;
        UnitAW: if (ddone) begin ux_l_q <= clamp14(dq); state_q <= UnitB; end
        UnitB: state_q <= UnitBW;
        UnitBW: if (ddone) begin uy_l_q <= clamp14(dq); state_q <= UnitC; end
        UnitC: state_q <= UnitCW;
        UnitCW: if (ddone) begin ux_r_q <= clamp14(dq); state_q <= UnitD; end
        UnitD: state_q <= UnitDW;
        UnitDW: if (ddone) begin uy_r_q <= clamp14(dq); state_q <= Blend; end
        Blend: state_q <= BlendW;
        BlendW: if (ddone) begin
          ty_q <= (tyw > 48'(lim)) ? lim : (tyw < -48'(lim)) ? -lim : 14'(tyw);
          state_q <= Clamp;
        end
        Clamp: state_q <= VecH;
        VecH: state_q <= WaitH;
        WaitH: if (cdone) begin
          head_q <= (hx == 0 && hy == 0) ? 15'sd0 : 15'(hcl);
          state_q <= Decide;
        end
        Decide: begin
          if (have_q && ddx <= 5 && ddx >= -5 && ddy <= 5 && ddy >= -5 &&
              ddh <= 204 && ddh >= -204) state_q <= Idle;
          else state_q <= Rot;
        end
        Rot: state_q <= WaitRot;
        WaitRot: if (cdone) begin
          qz_q <= 16'(qzc);
          qw_q <= 16'(qwc);
          state_q <= Emit;
        end
        Emit: if (emit_go) begin
          px_q <= tx_q;
          py_q <= ty_q;
          ph_q <= head_q;
          have_q <= 1'b1;
          odata_q <= {1'b0, qw_q, qz_q, head_q, ty_q, tx_q, rn_q};
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == Idle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
endmodule

>>> dv/goal_bisector_guard_position_checker.sv
`timescale 1ns / 1ps
module goal_bisector_guard_position_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ball_valid_i,
  input  logic        ball_ready_i,
  input  logic [31:0] ball_data_i,
  input  logic        guard_valid_i,
  input  logic        guard_ready_i,
  input  logic [79:0] guard_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          guard_count_o,
  output int          ball_count_o
);

  typedef struct packed {
    logic [3:0]  tag;
    logic [13:0] gx;
    logic [13:0] gy;
    logic [14:0] head;
    logic [15:0] qz;
    logic [15:0] qw;
  } guard_t;

  guard_t guard_q[$];

  longint line_x, width_mm, tag_cfg;
  longint last_x, last_y, last_head;
  bit     have_last;

  function automatic longint round_div(input longint n, input longint d);
    if (d <= 0) return 0;
    return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
  endfunction

  function automatic longint abs_l(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(input int i);
    logic signed [gbg_pkg::CordW-1:0] a;
    a = gbg_pkg::atan_q20(5'(i));
    return longint'(a);
  endfunction

  function automatic void polar(input longint xi, input longint yi,
                                output longint mag, output longint ang);
    longint x, y, z, xs, ys;
    x = xi * 256;
    y = yi * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(gbg_pkg::PiQ20) : -longint'(gbg_pkg::PiQ20);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < gbg_pkg::AtanN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end
    end
    if (x < 0) x = 0;
    mag = round_div(x * longint'(gbg_pkg::KinvQ30), 64'sd1 << 30);
    ang = z;
  endfunction

  function automatic longint unit_comp(input longint comp, input longint mag256);
    if (mag256 == 0) return 0;
    return clamp_l(round_div(comp * 256 * gbg_pkg::OneQ14, mag256),
                   -gbg_pkg::OneQ14, gbg_pkg::OneQ14);
  endfunction

  function automatic void sin_cos(input longint zi, output longint s, output longint c);
    longint x, y, z, xs, ys;
    x = longint'(gbg_pkg::KinvQ30);
    y = 0;
    z = zi;
    for (int i = 0; i < CORDIC_STEPS && i < gbg_pkg::AtanN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end
    end
    s = clamp_l((y + 32768) >>> 16, -gbg_pkg::OneQ14, gbg_pkg::OneQ14);
    c = clamp_l((x + 32768) >>> 16, -gbg_pkg::OneQ14, gbg_pkg::OneQ14);
  endfunction

  function automatic bit guard_target(input logic [31:0] d, output guard_t g);
    longint bx, by, tx, ty, gap, vx2, vl2, vr2, ml, mr, dummy;
    longint sx, sy, den, lim2, lim, hx, hy, head, m, a, qz, qw;
    bx = longint'($signed(d[13:0]));
    by = longint'($signed(d[27:14]));
    gap = abs_l(bx - line_x);
    tx = line_x;
    if (gap > 3000) tx = line_x + (line_x > 0 ? -400 : 400);
    else if (gap > 1500) tx = line_x + (line_x > 0 ? -150 : 150);
    vx2 = 2 * (line_x - bx);
    vl2 = width_mm - 2 * by;
    vr2 = -width_mm - 2 * by;
    polar(vx2, vl2, ml, dummy);
    polar(vx2, vr2, mr, dummy);
    sx = unit_comp(vx2, ml) + unit_comp(vx2, mr);
    sy = unit_comp(vl2, ml) + unit_comp(vr2, mr);
    den = abs_l(sx);
    if (den < 16) den = 16;
    ty = by + round_div(4 * (tx - bx) * sy, 5 * den);
    lim2 = width_mm - 180;
    if (lim2 < 0) lim2 = 0;
    lim = lim2 / 2;
    ty = clamp_l(ty, -lim, lim);
    hx = bx - tx;
    hy = by - ty;
    if (hx == 0 && hy == 0) begin
      head = 0;
    end else begin
      polar(hx, hy, m, a);
      head = clamp_l((a + 128) >>> 8, -gbg_pkg::HeadMax, gbg_pkg::HeadMax);
    end
    if (have_last && abs_l(tx - last_x) <= 5 && abs_l(ty - last_y) <= 5 &&
        abs_l(head - last_head) <= 204)
      return 0;
    sin_cos(head * 128, qz, qw);
    last_x = tx;
    last_y = ty;
    last_head = head;
    have_last = 1;
    g.tag = 4'(tag_cfg);
    g.gx = 14'(tx);
    g.gy = 14'(ty);
    g.head = 15'(head);
    g.qz = 16'(qz);
    g.qw = 16'(qw);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    guard_t e, r;
    if (!rst_ni) begin
      line_x = -4500;
      width_mm = 1000;
      tag_cfg = 0;
      last_x = 0;
      last_y = 0;
      last_head = 0;
      have_last = 0;
      guard_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      guard_count_o <= 0;
      ball_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gbg_pkg::CfgGoalLineX: line_x = longint'($signed(cfg_data_i));
          gbg_pkg::CfgGoalWidth: width_mm = longint'(cfg_data_i[11:0]);
          gbg_pkg::CfgRobotNumber: tag_cfg = longint'(cfg_data_i[3:0]);
          default: ;
        endcase
      end
      if (ball_valid_i && ball_ready_i) begin
        ball_count_o <= ball_count_o + 1;
        if (guard_target(ball_data_i, e)) guard_q.push_back(e);
      end
      if (guard_valid_i && guard_ready_i) begin
        guard_count_o <= guard_count_o + 1;
        r.tag = guard_data_i[3:0];
        r.gx = guard_data_i[17:4];
        r.gy = guard_data_i[31:18];
        r.head = guard_data_i[46:32];
        r.qz = guard_data_i[62:47];
        r.qw = guard_data_i[78:63];
        if (guard_q.size() == 0) begin
          $display("%0t: unexpected guard beat tag %0d x %0d y %0d head %0d z %0d w %0d",
                   $time, r.tag, $signed(r.gx), $signed(r.gy), $signed(r.head),
                   $signed(r.qz), $signed(r.qw));
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = guard_q.pop_front();
          if (r != e) begin
            $display("%0t: guard mismatch expected tag %0d x %0d y %0d head %0d z %0d w %0d",
                     $time, e.tag, $signed(e.gx), $signed(e.gy), $signed(e.head),
                     $signed(e.qz), $signed(e.qw));
            $display("%0t:                  actual tag %0d x %0d y %0d head %0d z %0d w %0d",
                     $time, r.tag, $signed(r.gx), $signed(r.gy), $signed(r.head),
                     $signed(r.qz), $signed(r.qw));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= guard_q.size();
    end
  end

endmodule

>>> dv/goal_bisector_guard_position_test.sv
`timescale 1ns / 1ps
module goal_bisector_guard_position_test;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles = 500;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [13:0] cfg_data_i;

  int fail_count, pending, guard_count, ball_count;
  int idle_pct;
  bit hold_req;
  int quiet_cycles;
  int phase_count;
  logic signed [13:0] last_bx, last_by;

  goal_bisector_guard_position u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  goal_bisector_guard_position_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .ball_valid_i(s_axis_tvalid), .ball_ready_i(s_axis_tready),
    .ball_data_i(s_axis_tdata),
    .guard_valid_i(m_axis_tvalid), .guard_ready_i(m_axis_tready),
    .guard_data_i(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending),
    .guard_count_o(guard_count), .ball_count_o(ball_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $time, WatchdogLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_ball(input logic signed [13:0] x, input logic signed [13:0] y);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, y, x};
    last_bx = x;
    last_by = y;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_field(input logic signed [13:0] gx, input logic [11:0] gw,
                           input logic [3:0] tag);
    drain();
    write_reg(gbg_pkg::CfgGoalLineX, gx);
    write_reg(gbg_pkg::CfgGoalWidth, {2'b0, gw});
    write_reg(gbg_pkg::CfgRobotNumber, {10'b0, tag});
  endtask

  task automatic directed_balls(input int gx, input int gw);
    int h;
    h = gw / 2;
    send_ball(14'(gx), 0);
    send_ball(14'(gx), 14'(h));
    send_ball(14'(gx), 14'(-h));
    send_ball(14'(gx + 1500), 0);
    send_ball(14'(gx + 1501), 14'(h + 7));
    send_ball(14'(gx - 3000), 14'(-h - 7));
    send_ball(14'(gx - 3001), 14'(h));
    send_ball(-14'sd8192, -14'sd8192);
    send_ball(14'sd8191, 14'sd8191);
    send_ball(14'sd8191, -14'sd8192);
    send_ball(-14'sd8192, 14'sd8191);
    send_ball(-14'sd8192, 14'sd8191);
  endtask

  task automatic random_balls(input int gx, input int n);
    int k, x, y;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        x = gx + $urandom_range(8000) - 4000;
        y = $urandom_range(6000) - 3000;
      end else if (k < 75) begin
        x = last_bx + $urandom_range(16) - 8;
        y = last_by + $urandom_range(16) - 8;
      end else begin
        x = $urandom_range(16383) - 8192;
        y = $urandom_range(16383) - 8192;
      end
      x = x < -8192 ? -8192 : (x > 8191 ? 8191 : x);
      y = y < -8192 ? -8192 : (y > 8191 ? 8191 : y);
      if (i == n / 2 && phase_count == 2) hold_req = 1;
      send_ball(14'(x), 14'(y));
    end
  endtask

  task automatic run_phase(input int gx, input int gw, input int tag, input int n);
    set_field(14'(gx), 12'(gw), 4'(tag));
    directed_balls(gx, gw);
    random_balls(gx, n);
    phase_count++;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gbg_pkg::CfgGoalLineX;
    cfg_data_i = '0;
    idle_pct = 34;
    hold_req = 0;
    quiet_cycles = 0;
    phase_count = 0;
    last_bx = 0;
    last_by = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_balls(-4500, 1000);
    random_balls(-4500, 190);
    phase_count++;
    run_phase(4500, 1000, 15, 110);
    run_phase(-4500, 1001, 5, 110);
    idle_pct = 0;
    run_phase(3000, 100, 9, 110);
    idle_pct = 34;
    run_phase(-8192, 4095, 0, 110);
    run_phase(8191, 0, 12, 110);
    run_phase(0, 181, 3, 110);
    for (int p = 0; p < 3; p++) begin
      run_phase($urandom_range(16383) - 8192, $urandom_range(4095), $urandom_range(15), 60);
    end

    drain();
    $display("Run sent %0d ball positions over %0d field settings; %0d guard targets checked.",
             ball_count, phase_count, guard_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
